>>> rtl/core/real_to_radix_digit_string_assert.svh
// Assertion macros for the real-to-radix digit string block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef REAL_TO_RADIX_DIGIT_STRING_ASSERT_SVH
`define REAL_TO_RADIX_DIGIT_STRING_ASSERT_SVH

// same-cycle implication
`define R2R_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define R2R_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/r2rds_pkg.sv
// Shared types, constants and helpers for the real-to-radix digit string block.
// No dependencies.
package r2rds_pkg;

  localparam int unsigned WHOLE_WIDTH         = 32;
  localparam int unsigned FRAC_BITS           = 32;
  localparam int unsigned MAX_FRAC_DIGITS_DEF = 10;
  localparam int unsigned RADIX_W             = 5;
  localparam int unsigned CHAR_W              = 7;
  localparam int unsigned DIGIT_W             = 4;

  localparam int unsigned DIV_BITS    = 8;
  localparam int unsigned DIV_CYCLES  = WHOLE_WIDTH / DIV_BITS;
  localparam int unsigned DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int unsigned STORE_DEPTH = WHOLE_WIDTH;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = STORE_IDX_W + 1;
  localparam int unsigned BIT_IDX_W   = $clog2(WHOLE_WIDTH);

  localparam logic [BIT_IDX_W-1:0] MIN_BIN_TOP = BIT_IDX_W'(3);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_BIN = RADIX_W'(2);

  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;

  typedef struct packed {
    logic signed [WHOLE_WIDTH-1:0] whole_part;
    logic [FRAC_BITS-1:0]          frac_part;
    logic [RADIX_W-1:0]            radix;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              bad_radix;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_ZERO,
    ST_DIV,
    ST_SIGN,
    ST_DIG,
    ST_BIN,
    ST_DOT,
    ST_FRAC
  } state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ERR,
    EMIT_ZERO,
    EMIT_MINUS,
    EMIT_DOT,
    EMIT_STORE,
    EMIT_BIT,
    EMIT_FRAC
  } emit_e;

  typedef struct packed {
    logic  load;
    logic  div_step;
    emit_e emit;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic bad_radix;
    logic mag_zero;
    logic neg;
    logic bin_neg;
    logic frac_nz;
    logic div_done;
    logic count_one;
    logic bidx_zero;
    logic frac_end;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      return CH_ZERO + dx;
    end else begin
      return CH_A + dx - CHAR_W'(10);
    end
  endfunction

endpackage

>>> rtl/core/r2rds_ctrl.sv
// Sequencing state machine of the real-to-radix digit string block.
// Depends on r2rds_pkg; drives the datapath by cmd_t, reads status_t.
module r2rds_ctrl
  import r2rds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output logic    busy_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.load     = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.emit     = EMIT_NONE;
    cmd_o.last     = 1'b0;
    busy_o         = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (status_i.bad_radix) begin
            state_d = ST_ERR;
          end else if (status_i.mag_zero) begin
            state_d = ST_ZERO;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_ERR: begin
        cmd_o.emit = EMIT_ERR;
        cmd_o.last = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_ZERO: begin
        cmd_o.emit = EMIT_ZERO;
        cmd_o.last = !status_i.frac_nz;
        state_d    = status_i.frac_nz ? ST_DOT : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          if (status_i.bin_neg) begin
            state_d = ST_BIN;
          end else if (status_i.neg) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_DIG;
          end
        end
      end
      ST_SIGN: begin
        cmd_o.emit = EMIT_MINUS;
        state_d    = ST_DIG;
      end
      ST_DIG: begin
        cmd_o.emit = EMIT_STORE;
        cmd_o.last = status_i.count_one && !status_i.frac_nz;
        if (status_i.count_one) begin
          state_d = status_i.frac_nz ? ST_DOT : ST_IDLE;
        end
      end
      ST_BIN: begin
        cmd_o.emit = EMIT_BIT;
        cmd_o.last = status_i.bidx_zero && !status_i.frac_nz;
        if (status_i.bidx_zero) begin
          state_d = status_i.frac_nz ? ST_DOT : ST_IDLE;
        end
      end
      ST_DOT: begin
        cmd_o.emit = EMIT_DOT;
        state_d    = ST_FRAC;
      end
      ST_FRAC: begin
        cmd_o.emit = EMIT_FRAC;
        cmd_o.last = status_i.frac_end;
        if (status_i.frac_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/r2rds_datapath.sv
// Datapath of the real-to-radix digit string block: radix divider, digit
// store, fraction multiplier and the result register. Depends on r2rds_pkg.
module r2rds_datapath
  import r2rds_pkg::*;
#(
  parameter int unsigned MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int unsigned PROD_W = FRAC_BITS + RADIX_W;

  logic [RADIX_W-1:0]     radix_q;
  logic [WHOLE_WIDTH-1:0] quot_q;
  logic [WHOLE_WIDTH-1:0] tc_q;
  logic [DIGIT_W-1:0]     part_q;
  logic [DIV_CNT_W-1:0]   sub_q;
  logic [COUNT_W-1:0]     count_q;
  logic [BIT_IDX_W-1:0]   bidx_q;
  logic [FRAC_BITS-1:0]   frac_q;
  logic [FCNT_W-1:0]      fcnt_q;
  logic                   neg_q;
  logic                   bin_neg_q;
  logic                   frac_nz_q;
  logic [DIGIT_W-1:0]     store_q [STORE_DEPTH];
  logic                   valid_q;
  result_t                result_q, result_d;

  logic [WHOLE_WIDTH-1:0] w_u;
  logic [WHOLE_WIDTH-1:0] mag;
  logic                   in_neg;
  logic [WHOLE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_part;
  logic                   div_last;
  logic [COUNT_W-1:0]     count_m1;
  logic [COUNT_W-1:0]     len;
  logic [BIT_IDX_W-1:0]   bin_top;
  logic [STORE_IDX_W-1:0] rd_idx;
  logic [PROD_W-1:0]      prod;
  logic [DIGIT_W-1:0]     frac_digit;
  logic [FRAC_BITS-1:0]   frac_next;

  // magnitude of the whole part; the most negative code saturates
  assign w_u    = item_i.whole_part;
  assign in_neg = w_u[WHOLE_WIDTH-1];
  always_comb begin
    if (w_u == {1'b1, {(WHOLE_WIDTH-1){1'b0}}}) begin
      mag = {1'b0, {(WHOLE_WIDTH-1){1'b1}}};
    end else if (in_neg) begin
      mag = '0 - w_u;
    end else begin
      mag = w_u;
    end
  end

  // DIV_BITS restoring steps per cycle on a narrow partial remainder
  always_comb begin
    logic [DIGIT_W:0]       trial;
    logic [DIGIT_W-1:0]     part;
    logic [WHOLE_WIDTH-1:0] quot;
    part = part_q;
    quot = quot_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {part, quot[WHOLE_WIDTH-1]};
      quot  = {quot[WHOLE_WIDTH-2:0], 1'b0};
      if (trial >= radix_q) begin
        trial   = trial - radix_q;
        quot[0] = 1'b1;
      end
      part = trial[DIGIT_W-1:0];
    end
    div_quot = quot;
    div_part = part;
  end

  assign div_last = (sub_q == DIV_CNT_W'(DIV_CYCLES - 1));
  assign count_m1 = count_q - COUNT_W'(1);
  assign rd_idx   = count_m1[STORE_IDX_W-1:0];
  assign len      = count_q + COUNT_W'(1);
  assign bin_top  = (len < COUNT_W'(MIN_BIN_TOP)) ? MIN_BIN_TOP : len[BIT_IDX_W-1:0];

  assign prod       = PROD_W'(frac_q) * PROD_W'(radix_q);
  assign frac_digit = prod[FRAC_BITS +: DIGIT_W];
  assign frac_next  = prod[FRAC_BITS-1:0];

  assign status_o.bad_radix = (item_i.radix < RADIX_MIN) || (item_i.radix > RADIX_MAX);
  assign status_o.mag_zero  = (w_u == '0);
  assign status_o.neg       = neg_q;
  assign status_o.bin_neg   = bin_neg_q;
  assign status_o.frac_nz   = frac_nz_q;
  assign status_o.div_done  = div_last && (div_quot == '0);
  assign status_o.count_one = (count_q == COUNT_W'(1));
  assign status_o.bidx_zero = (bidx_q == '0);
  assign status_o.frac_end  = (frac_next == '0) || (fcnt_q == FCNT_W'(MAX_FRAC_DIGITS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q   <= item_i.radix;
      quot_q    <= mag;
      tc_q      <= '0 - mag;
      part_q    <= '0;
      sub_q     <= '0;
      count_q   <= '0;
      bidx_q    <= '0;
      neg_q     <= in_neg;
      bin_neg_q <= in_neg && (item_i.radix == RADIX_BIN);
      frac_q    <= item_i.frac_part;
      frac_nz_q <= (item_i.frac_part != '0);
      fcnt_q    <= '0;
    end
    if (cmd_i.div_step) begin
      quot_q <= div_quot;
      if (div_last) begin
        sub_q                             <= '0;
        part_q                            <= '0;
        store_q[count_q[STORE_IDX_W-1:0]] <= div_part;
        count_q                           <= len;
        bidx_q                            <= bin_top;
      end else begin
        sub_q  <= sub_q + DIV_CNT_W'(1);
        part_q <= div_part;
      end
    end
    case (cmd_i.emit)
      EMIT_STORE: count_q <= count_m1;
      EMIT_BIT:   bidx_q <= bidx_q - BIT_IDX_W'(1);
      EMIT_FRAC: begin
        frac_q <= frac_next;
        fcnt_q <= fcnt_q + FCNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    result_d.last      = cmd_i.last;
    result_d.bad_radix = 1'b0;
    unique case (cmd_i.emit)
      EMIT_NONE:  result_d.char_code = CH_NUL;
      EMIT_ERR: begin
        result_d.char_code = CH_NUL;
        result_d.bad_radix = 1'b1;
      end
      EMIT_ZERO:  result_d.char_code = CH_ZERO;
      EMIT_MINUS: result_d.char_code = CH_MINUS;
      EMIT_DOT:   result_d.char_code = CH_DOT;
      EMIT_STORE: result_d.char_code = digit_char(store_q[rd_idx]);
      EMIT_BIT:   result_d.char_code = tc_q[bidx_q] ? CH_ONE : CH_ZERO;
      EMIT_FRAC:  result_d.char_code = digit_char(frac_digit);
      default:    result_d.char_code = CH_NUL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

>>> rtl/core/real_to_radix_digit_string.sv
// Top level of the real-to-radix digit string block.
// Depends on r2rds_pkg, r2rds_ctrl, r2rds_datapath and the assertion header.
//
// Usage: drive item_i and raise start_i; the item is taken at a rising edge
// with start_i high and busy_o low. busy_o stays high until the last
// character has been issued. Characters come out one per beat on result_o,
// each valid for exactly one cycle with result_valid_o high; the final one
// has last set. The receiver cannot hold results off and must take every beat.
// An invalid radix gives a single beat with bad_radix and last set.
// Operation: the item is loaded, then the whole part is divided by the radix,
// eight quotient bits per cycle, one whole-part digit per full division, then
// the characters are issued in order (sign, digits or two's-complement bits,
// point, fraction digits). The first character appears in the cycle after
// its state is entered, through the result register.
// Reset: asynchronous, active low; the block returns idle with no beat pending
// and is ready for a start on the first cycle after reset is released.
`include "real_to_radix_digit_string_assert.svh"
module real_to_radix_digit_string
  import r2rds_pkg::*;
#(
  parameter int unsigned MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  item_t   item_i,
  output logic    busy_o,
  output logic    result_valid_o,
  output result_t result_o
);

  cmd_t    cmd;
  status_t status;

  r2rds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  r2rds_datapath #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `R2R_ASSERT_IMP(a_last_ends_busy, result_valid_o && result_o.last, !busy_o, "busy after last beat")
  `R2R_ASSERT_IMP(a_mid_keeps_busy, result_valid_o && !result_o.last, busy_o, "idle mid-string")
  `R2R_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted item did not start")
  `R2R_ASSERT_IMP(a_err_alone, result_valid_o && result_o.bad_radix, result_o.last && (result_o.char_code == CH_NUL), "error beat malformed")

endmodule

>>> tb/real_to_radix_digit_string_tb.sv
// Testbench for real_to_radix_digit_string: a directed table then random items,
// each conversion's character beats checked against exact text or an in-bench predictor.
// Depends on r2rds_pkg and the real_to_radix_digit_string top level.
module real_to_radix_digit_string_tb
  import r2rds_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    item_t stim;
    string golden; // "" = predictor, "ERR" = bad radix beat, else the exact text
  } case_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  item_t   item_i;
  logic    busy_o;
  logic    result_valid_o;
  result_t result_o;

  result_t pending_chars[$];
  case_t   directed_cases[$];
  int      error_count;
  int      cycle_count;

  real_to_radix_digit_string DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] d);
    string glyphs;
    glyphs = "0123456789ABCDEF";
    return CHAR_W'(glyphs[d]);
  endfunction

  function automatic result_t char_beat(input logic [CHAR_W-1:0] c);
    result_t b;
    b.char_code = c;
    b.last      = 1'b0;
    b.bad_radix = 1'b0;
    return b;
  endfunction

  function automatic void push_conversion(ref result_t chars[$]);
    chars[chars.size()-1].last = 1'b1;
    foreach (chars[k]) pending_chars.push_back(chars[k]);
  endfunction

  function automatic void push_bad_radix();
    result_t b;
    b.char_code = CH_NUL;
    b.last      = 1'b1;
    b.bad_radix = 1'b1;
    pending_chars.push_back(b);
  endfunction

  function automatic void push_text(input string s);
    result_t chars[$];
    if (s == "ERR") begin
      push_bad_radix();
      return;
    end
    for (int k = 0; k < s.len(); k++) chars.push_back(char_beat(CHAR_W'(s[k])));
    push_conversion(chars);
  endfunction

  // Expected character string for one conversion.
  function automatic void predict_digit_string(input item_t it);
    logic [31:0]      w;
    logic [31:0]      mag;
    logic [31:0]      quo;
    logic [31:0]      rem;
    logic [63:0]      twos;
    logic [63:0]      prod;
    logic [RADIX_W-1:0] r;
    logic             neg;
    logic [3:0]       digs[$];
    result_t          chars[$];
    int               len;
    int               width;
    r = it.radix;
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      push_bad_radix();
      return;
    end
    w   = it.whole_part;
    neg = w[31];
    if (!neg) mag = w;
    else if (w == 32'h8000_0000) mag = 32'h7FFF_FFFF;
    else mag = -w;
    if (mag == 0) begin
      chars.push_back(char_beat(CH_ZERO));
    end else if (neg && r == RADIX_BIN) begin
      len = 0;
      for (int k = 0; k < 32; k++) if (mag[k]) len = k + 1;
      width = (len + 1 < 4) ? 4 : len + 1;
      twos  = 64'd0 - {32'd0, mag};
      for (int k = width - 1; k >= 0; k--) chars.push_back(char_beat(twos[k] ? CH_ONE : CH_ZERO));
    end else begin
      quo = mag;
      while (quo != 0) begin
        digs.push_back(4'(quo % r));
        quo = quo / r;
      end
      if (neg) chars.push_back(char_beat(CH_MINUS));
      for (int k = digs.size() - 1; k >= 0; k--) chars.push_back(char_beat(hex_glyph(digs[k])));
    end
    rem = it.frac_part;
    if (rem != 0) begin
      chars.push_back(char_beat(CH_DOT));
      for (int k = 0; k < MAX_FRAC_DIGITS_DEF && rem != 0; k++) begin
        prod = {32'd0, rem} * {59'd0, r};
        rem  = prod[31:0];
        chars.push_back(char_beat(hex_glyph(prod[35:32])));
      end
    end
    push_conversion(chars);
  endfunction

  function automatic case_t mk(input logic [31:0] w, input logic [31:0] f,
                               input logic [RADIX_W-1:0] r, input string g);
    case_t c;
    c.stim.whole_part = w;
    c.stim.frac_part  = f;
    c.stim.radix      = r;
    c.golden          = g;
    return c;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    logic [31:0] mag;
    int          nbits;
    nbits = $urandom_range(0, 32);
    mag   = (nbits == 32) ? $urandom : ($urandom & ((32'd1 << nbits) - 1));
    case ($urandom_range(0, 15))
      0:       mag = 32'h7FFF_FFFF;
      1:       mag = 32'h8000_0000;
      default: mag[31] = (nbits == 32) ? mag[31] : 1'b0;
    endcase
    it.whole_part = $urandom_range(0, 1) ? -mag : mag;
    case ($urandom_range(0, 3))
      0:       it.frac_part = '0;
      1:       it.frac_part = $urandom & (32'hFFFF_FFFF << $urandom_range(22, 31));
      default: it.frac_part = $urandom;
    endcase
    it.radix = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom_range(0, 31))
                                           : RADIX_W'($urandom_range(2, 16));
    return it;
  endfunction

  // One beat on the command side; expectations are queued once busy_o is seen low after a rising edge.
  task automatic send_item(input item_t it, input string golden, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    if (golden == "") predict_digit_string(it);
    else push_text(golden);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: char_code %0h last %0b bad_radix %0b",
               result_o.char_code, result_o.last, result_o.bad_radix);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (result_o.char_code !== want.char_code) begin
          $error("char_code: expected %0h, got %0h", want.char_code, result_o.char_code);
          error_count++;
        end
        if (result_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_o.last);
          error_count++;
        end
        if (result_o.bad_radix !== want.bad_radix) begin
          $error("bad_radix: expected %0b, got %0b", want.bad_radix, result_o.bad_radix);
          error_count++;
        end
      end
    end
  end

  initial begin
    int gap;
    error_count = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;

    directed_cases.push_back(mk(32'd0, 32'd0, 5'd10, "0"));
    directed_cases.push_back(mk(32'd0, 32'd0, 5'd0, "ERR"));
    directed_cases.push_back(mk(32'd0, 32'd0, 5'd1, "ERR"));
    directed_cases.push_back(mk(32'd0, 32'd0, 5'd17, "ERR"));
    directed_cases.push_back(mk(-32'sd1, 32'hFFFF_FFFF, 5'd31, "ERR"));
    directed_cases.push_back(mk(32'd1, 32'd0, 5'd2, "1"));
    directed_cases.push_back(mk(-32'sd1, 32'd0, 5'd2, "1111"));
    directed_cases.push_back(mk(-32'sd7, 32'd0, 5'd2, "1001"));
    directed_cases.push_back(mk(-32'sd8, 32'd0, 5'd2, ""));
    directed_cases.push_back(mk(-32'sd1, 32'd0, 5'd10, "-1"));
    directed_cases.push_back(mk(32'h7FFF_FFFF, 32'd0, 5'd16, "7FFFFFFF"));
    directed_cases.push_back(mk(32'h8000_0001, 32'd0, 5'd16, "-7FFFFFFF"));
    directed_cases.push_back(mk(32'h8000_0000, 32'd0, 5'd16, "-7FFFFFFF"));
    directed_cases.push_back(mk(32'h8000_0000, 32'd0, 5'd2, ""));
    directed_cases.push_back(mk(32'h7FFF_FFFF, 32'd0, 5'd2, ""));
    directed_cases.push_back(mk(32'd0, 32'h8000_0000, 5'd10, "0.5"));
    directed_cases.push_back(mk(32'd0, 32'h8000_0000, 5'd16, "0.8"));
    directed_cases.push_back(mk(32'd0, 32'hFFFF_FFFF, 5'd16, "0.FFFFFFFF"));
    directed_cases.push_back(mk(32'd0, 32'd1, 5'd10, ""));
    directed_cases.push_back(mk(32'd0, 32'hFFFF_FFFF, 5'd3, ""));
    directed_cases.push_back(mk(-32'sd5, 32'h4000_0000, 5'd2, ""));
    directed_cases.push_back(mk(-32'sd123456, 32'h1234_5678, 5'd7, ""));
    directed_cases.push_back(mk(32'd255, 32'd0, 5'd15, ""));
    directed_cases.push_back(mk(32'd12345, 32'hDEAD_BEEF, 5'd13, ""));
    directed_cases.push_back(mk(32'h8000_0000, 32'h0000_0001, 5'd2, ""));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_cases[k]) send_item(directed_cases[k].stim, directed_cases[k].golden,
                                          $urandom_range(0, 7));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gap = ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
      send_item(random_item(), "", gap);
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
